/* hw/rtl/trsa_pkg.sv */
// Package for the toy RSA character encryptor: shared types, codes and constants.
// No dependencies; compile first.
`timescale 1ns / 1ps

package trsa_pkg;

    localparam logic [7:0] CHAR_OFFSET = 8'd96;
    localparam logic [5:0] RESET_P     = 6'd3;
    localparam logic [5:0] RESET_Q     = 6'd7;

    // Exponent candidates: the first eight primes. At most five divide a totient t
    // below 4096 and two more can equal p or q; one remains, used only if below t.
    localparam int CAND_W    = 3;
    localparam int EXP_W     = 5;
    localparam logic [CAND_W-1:0] LAST_CAND = CAND_W'(7);

    // Serial reduction: one bit of the multiplier per step.
    localparam int BITS_W    = 12;
    localparam int STEP_W    = 4;
    localparam int DIV_STEPS = 12;
    localparam int MUL_STEPS = 8;

    // Register index codes (byte address bit 2).
    localparam logic REG_PRIME_P = 1'b0;
    localparam logic REG_PRIME_Q = 1'b1;

    typedef enum logic [2:0] {
        ST_KEYS,
        ST_SEARCH,
        ST_DIV,
        ST_CHECK,
        ST_IDLE,
        ST_MUL,
        ST_RUPD,
        ST_FINISH
    } t_state;

    typedef enum logic [2:0] {
        DP_NOP,
        DP_KEYS,
        DP_DIV_LOAD,
        DP_STEP,
        DP_SET_E,
        DP_ITEM_LOAD,
        DP_ROUND_END,
        DP_OUT
    } t_dp_op;

    typedef struct packed {
        t_dp_op            op;
        logic [CAND_W-1:0] cand_idx;
    } t_dp_cmd;

    typedef struct packed {
        logic [EXP_W-1:0] exp;
        logic             cand_lt_t;
        logic             cand_ok;
        logic             out_free;
    } t_dp_stat;

    function automatic logic [EXP_W-1:0] cand_prime(input logic [CAND_W-1:0] idx);
        logic [EXP_W-1:0] v;
        unique case (idx)
            3'd0: v = 5'd2;
            3'd1: v = 5'd3;
            3'd2: v = 5'd5;
            3'd3: v = 5'd7;
            3'd4: v = 5'd11;
            3'd5: v = 5'd13;
            3'd6: v = 5'd17;
            3'd7: v = 5'd19;
        endcase
        return v;
    endfunction

endpackage

/* hw/rtl/trsa_if.sv */
// Valid/ready channel interfaces for character input and cipher output.
// No dependencies.
`timescale 1ns / 1ps

interface trsa_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] char_code;
    logic       last_of_word;

    modport source(output valid, char_code, last_of_word, input ready);
    modport sink(input valid, char_code, last_of_word, output ready);
endinterface

interface trsa_out_if;
    logic              valid;
    logic              ready;
    logic signed [12:0] residue;
    logic [7:0]        cipher_byte;
    logic [7:0]        word_number;
    logic              word_end;

    modport source(output valid, residue, cipher_byte, word_number, word_end, input ready);
    modport sink(input valid, residue, cipher_byte, word_number, word_end, output ready);
endinterface

/* hw/rtl/trsa_dp.sv */
// Datapath: key registers, shared serial modular reducer, item and output registers.
// Depends on trsa_pkg.
`timescale 1ns / 1ps

module trsa_dp import trsa_pkg::*; (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  t_dp_cmd            i_cmd,
    input  logic [5:0]         i_prime_p,
    input  logic [5:0]         i_prime_q,
    input  logic [7:0]         i_char_code,
    input  logic               i_last_of_word,
    input  logic               i_out_ready,
    output t_dp_stat           o_stat,
    output logic               o_out_valid,
    output logic signed [12:0] o_residue,
    output logic [7:0]         o_cipher_byte,
    output logic [7:0]         o_word_number,
    output logic               o_word_end
);

    // key state
    logic [11:0]        r_mod_n;
    logic signed [12:0] r_tot;
    logic [EXP_W-1:0]   r_exp;
    // reducer
    logic [11:0]        r_acc;
    logic [11:0]        r_mul;
    logic [11:0]        r_modv;
    logic [BITS_W-1:0]  r_bits;
    // current item
    logic [7:0]         r_abs_pt;
    logic               r_spt;
    logic               r_sign;
    logic [7:0]         r_wnum;
    logic               r_wend;
    logic [7:0]         r_wcnt;
    // output register
    logic               r_out_valid;
    logic signed [12:0] r_out_res;
    logic [7:0]         r_out_cipher;
    logic [7:0]         r_out_wnum;
    logic               r_out_wend;

    logic [EXP_W-1:0]   w_cand;
    logic [11:0]        w_n;
    logic signed [6:0]  w_pm1;
    logic signed [6:0]  w_qm1;
    logic signed [13:0] w_tot;
    logic [8:0]         w_pt;
    logic [8:0]         w_pt_neg;
    logic [7:0]         w_abs_pt;
    logic [13:0]        w_sum;
    logic [13:0]        w_m1;
    logic [13:0]        w_m2;
    logic [11:0]        w_red;
    logic [12:0]        w_mag;
    logic signed [12:0] w_res;

    assign w_cand = cand_prime(i_cmd.cand_idx);

    assign w_n   = i_prime_p * i_prime_q;
    assign w_pm1 = $signed({1'b0, i_prime_p}) - 7'sd1;
    assign w_qm1 = $signed({1'b0, i_prime_q}) - 7'sd1;
    assign w_tot = w_pm1 * w_qm1;

    assign w_pt     = {1'b0, i_char_code} - {1'b0, CHAR_OFFSET};
    assign w_pt_neg = -w_pt;
    assign w_abs_pt = w_pt[8] ? w_pt_neg[7:0] : w_pt[7:0];

    // acc <- (2*acc + bit*mul) mod modv; inputs below modv keep the sum under 3*modv
    assign w_sum = {1'b0, r_acc, 1'b0} + (r_bits[BITS_W-1] ? {2'b00, r_mul} : 14'd0);
    assign w_m1  = {2'b00, r_modv};
    assign w_m2  = {1'b0, r_modv, 1'b0};

    always_comb begin
        if (w_sum >= w_m2) begin
            w_red = 12'(w_sum - w_m2);
        end else if (w_sum >= w_m1) begin
            w_red = 12'(w_sum - w_m1);
        end else begin
            w_red = w_sum[11:0];
        end
    end

    assign w_mag = {1'b0, r_mul};
    assign w_res = r_sign ? $signed(-w_mag) : $signed(w_mag);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
            r_wcnt      <= 8'd0;
            r_exp       <= '0;
        end else begin
            if (i_cmd.op == DP_OUT) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            if (i_cmd.op == DP_KEYS) begin
                r_exp <= '0;
            end else if (i_cmd.op == DP_SET_E) begin
                r_exp <= w_cand;
            end
            if (i_cmd.op == DP_ITEM_LOAD && i_last_of_word) begin
                r_wcnt <= r_wcnt + 8'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        unique case (i_cmd.op)
            DP_NOP, DP_SET_E: begin
            end
            DP_KEYS: begin
                r_mod_n <= w_n;
                r_tot   <= w_tot[12:0];
            end
            DP_DIV_LOAD: begin
                r_acc  <= 12'd0;
                r_mul  <= 12'd1;
                r_modv <= {7'd0, w_cand};
                r_bits <= r_tot[11:0];
            end
            DP_STEP: begin
                r_acc  <= w_red;
                r_bits <= {r_bits[BITS_W-2:0], 1'b0};
            end
            DP_ITEM_LOAD: begin
                r_acc    <= 12'd0;
                r_mul    <= 12'd1;
                r_sign   <= 1'b0;
                r_modv   <= r_mod_n;
                r_bits   <= {w_abs_pt, 4'd0};
                r_abs_pt <= w_abs_pt;
                r_spt    <= w_pt[8];
                r_wnum   <= r_wcnt;
                r_wend   <= i_last_of_word;
            end
            DP_ROUND_END: begin
                r_mul  <= r_acc;
                r_sign <= r_sign ^ r_spt;
                r_acc  <= 12'd0;
                r_bits <= {r_abs_pt, 4'd0};
            end
            DP_OUT: begin
                r_out_res    <= w_res;
                r_out_cipher <= w_res[7:0] + CHAR_OFFSET;
                r_out_wnum   <= r_wnum;
                r_out_wend   <= r_wend;
            end
        endcase
    end

    assign o_stat.exp       = r_exp;
    assign o_stat.cand_lt_t = $signed({8'd0, w_cand}) < r_tot;
    assign o_stat.cand_ok   = (r_acc != 12'd0) && ({1'b0, w_cand} != i_prime_p)
                              && ({1'b0, w_cand} != i_prime_q);
    assign o_stat.out_free  = !r_out_valid || i_out_ready;

    assign o_out_valid   = r_out_valid;
    assign o_residue     = r_out_res;
    assign o_cipher_byte = r_out_cipher;
    assign o_word_number = r_out_wnum;
    assign o_word_end    = r_out_wend;

    // reducer keeps its accumulator below the modulus after every step
    a_acc_reduced: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.op == DP_STEP) |=> (r_acc < r_modv))
        else $error("reducer accumulator not below modulus");

    // an exponent only exists with a modulus of at least four
    a_exp_mod: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_exp != '0) |-> (r_mod_n >= 12'd4))
        else $error("nonzero exponent with tiny modulus");

endmodule

/* hw/rtl/trsa_ctrl.sv */
// Controller: sequences key derivation, exponentiation rounds and result hand-off.
// Depends on trsa_pkg.
`timescale 1ns / 1ps

module trsa_ctrl import trsa_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_cfg_wr,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state              r_state, n_state;
    logic [CAND_W-1:0]   r_idx, n_idx;
    logic [STEP_W-1:0]   r_step, n_step;
    logic [EXP_W-1:0]    r_rnd, n_rnd;
    logic                w_last_rnd;

    assign w_last_rnd = (EXP_W'(r_rnd + 1'b1) == i_stat.exp);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_KEYS;
            r_idx   <= '0;
            r_step  <= '0;
            r_rnd   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
            r_step  <= n_step;
            r_rnd   <= n_rnd;
        end
    end

    // next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_KEYS:   n_state = ST_SEARCH;
            ST_SEARCH: n_state = i_stat.cand_lt_t ? ST_DIV : ST_IDLE;
            ST_DIV: begin
                if (r_step == '0) n_state = ST_CHECK;
            end
            ST_CHECK: begin
                n_state = (i_stat.cand_ok || r_idx == LAST_CAND) ? ST_IDLE : ST_SEARCH;
            end
            ST_IDLE: begin
                if (i_in_valid) n_state = (i_stat.exp == '0) ? ST_FINISH : ST_MUL;
            end
            ST_MUL: begin
                if (r_step == '0) n_state = ST_RUPD;
            end
            ST_RUPD:   n_state = w_last_rnd ? ST_FINISH : ST_MUL;
            ST_FINISH: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default:   n_state = ST_KEYS;
        endcase
        if (i_cfg_wr) n_state = ST_KEYS;
    end

    // outputs and counters
    always_comb begin
        o_cmd.op       = DP_NOP;
        o_cmd.cand_idx = r_idx;
        o_in_ready     = 1'b0;
        n_idx          = r_idx;
        n_step         = r_step;
        n_rnd          = r_rnd;
        unique case (r_state)
            ST_KEYS: begin
                o_cmd.op = DP_KEYS;
                n_idx    = '0;
            end
            ST_SEARCH: begin
                if (i_stat.cand_lt_t) begin
                    o_cmd.op = DP_DIV_LOAD;
                    n_step   = STEP_W'(DIV_STEPS - 1);
                end
            end
            ST_DIV: begin
                o_cmd.op = DP_STEP;
                n_step   = r_step - 1'b1;
            end
            ST_CHECK: begin
                if (i_stat.cand_ok) begin
                    o_cmd.op = DP_SET_E;
                end else begin
                    n_idx = r_idx + 1'b1;
                end
            end
            ST_IDLE: begin
                o_in_ready = !i_cfg_wr;
                if (i_in_valid && !i_cfg_wr) begin
                    o_cmd.op = DP_ITEM_LOAD;
                    n_step   = STEP_W'(MUL_STEPS - 1);
                    n_rnd    = '0;
                end
            end
            ST_MUL: begin
                o_cmd.op = DP_STEP;
                n_step   = r_step - 1'b1;
            end
            ST_RUPD: begin
                o_cmd.op = DP_ROUND_END;
                n_step   = STEP_W'(MUL_STEPS - 1);
                n_rnd    = r_rnd + 1'b1;
            end
            ST_FINISH: begin
                if (i_stat.out_free) o_cmd.op = DP_OUT;
            end
            default: begin
            end
        endcase
    end

    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_cmd.op == DP_OUT) |-> i_stat.out_free)
        else $error("result loaded over an untaken result");

    a_rnd_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == ST_MUL) |-> (r_rnd < i_stat.exp))
        else $error("round count past exponent");

    a_item_path: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_in_ready && i_in_valid) |=> (r_state == ST_MUL || r_state == ST_FINISH))
        else $error("accepted transaction did not start exponentiation");

endmodule

/* hw/rtl/toy_rsa_character_encryptor.sv */
// Top level of the toy RSA character encryptor: APB register file, controller, datapath.
// Depends on trsa_pkg, trsa_if, trsa_ctrl, trsa_dp.
`timescale 1ns / 1ps

// Usage
//   Configuration: APB-style port, registers prime_p at 0x0 and prime_q at 0x4
//   (6-bit values, pready tied high). A write restarts key derivation:
//   n = p*q, t = (p-1)*(q-1), e = smallest of the first eight primes below t
//   that does not divide t and is neither p nor q (0 if none). Derivation is a
//   key load, then at most eight candidates, each a compare, twelve serial
//   t-mod-candidate steps and a check; i_char.ready stays low meanwhile and in
//   the write's access cycle.
//   Reset: p=3, q=7, word counter cleared, then the same derivation (e=5).
//   Input i_char: one character transaction per valid/ready handshake.
//   Output o_cipher: one result transaction per character, in order.
//   Rounds: each of the e rounds is a bit-serial modular multiply
//   (one multiplier bit per cycle through the shared reducer) followed by a
//   round update that latches the product. The result register loads in
//   ST_FINISH, entered after the last round update or directly from ST_IDLE
//   when e is 0, and the next character is accepted back in ST_IDLE.
//   The result sits in an output register; the next character is accepted
//   while it waits. If the receiver stalls, the following result is held
//   inside and no further character is taken until the output register frees.

module toy_rsa_character_encryptor import trsa_pkg::*; (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready,
    trsa_in_if.sink     i_char,
    trsa_out_if.source  o_cipher
);

    logic [5:0] r_prime_p;
    logic [5:0] r_prime_q;
    logic       w_cfg_wr;
    t_dp_cmd    w_cmd;
    t_dp_stat   w_stat;

    // register write on the APB access phase
    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_prime_p <= RESET_P;
            r_prime_q <= RESET_Q;
        end else if (w_cfg_wr) begin
            unique case (paddr[2])
                REG_PRIME_P: r_prime_p <= pwdata[5:0];
                REG_PRIME_Q: r_prime_q <= pwdata[5:0];
            endcase
        end
    end

    always_comb begin
        unique case (paddr[2])
            REG_PRIME_P: prdata = {26'd0, r_prime_p};
            REG_PRIME_Q: prdata = {26'd0, r_prime_q};
        endcase
    end

    trsa_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_cfg_wr   (w_cfg_wr),
        .i_in_valid (i_char.valid),
        .i_stat     (w_stat),
        .o_in_ready (i_char.ready),
        .o_cmd      (w_cmd)
    );

    trsa_dp u_dp (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_prime_p      (r_prime_p),
        .i_prime_q      (r_prime_q),
        .i_char_code    (i_char.char_code),
        .i_last_of_word (i_char.last_of_word),
        .i_out_ready    (o_cipher.ready),
        .o_stat         (w_stat),
        .o_out_valid    (o_cipher.valid),
        .o_residue      (o_cipher.residue),
        .o_cipher_byte  (o_cipher.cipher_byte),
        .o_word_number  (o_cipher.word_number),
        .o_word_end     (o_cipher.word_end)
    );

endmodule
